[rtl/mffd_pkg.sv]
`default_nettype none
package mffd_pkg;

  typedef enum logic [3:0] {
    PH_HEADER, PH_TAG, PH_VARINT, PH_LENGTH, PH_TEXT, PH_SKIP, PH_STOP,
    PH_DROP_ADDR, PH_DROP_DUP
  } phase_t;

  typedef enum logic [2:0] {
    V_ACCEPTED = 3'd0, V_SHORT = 3'd1, V_NOT_ADDR = 3'd2, V_DUP = 3'd3, V_NO_TEXT = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_SEARCH, BK_EMIT
  } back_state_t;

  localparam logic [31:0] BROADCAST_ID = 32'hFFFF_FFFF;
  localparam logic [2:0]  WT_VARINT    = 3'd0;
  localparam logic [2:0]  WT_LENDELIM  = 3'd2;
  localparam logic [4:0]  FIELD_PORT   = 5'd1;
  localparam logic [4:0]  FIELD_TEXT   = 5'd2;

  // request passed from the front queue to the back end
  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] own_id;
  } req_t;

  // one result entry
  typedef struct packed {
    logic        kind;
    logic [7:0]  text_byte;
    logic        text_first;
    logic [2:0]  verdict;
    logic [31:0] sender_id;
    logic [31:0] port_number;
    logic        frame_done;
  } res_t;

endpackage
`default_nettype wire

[rtl/mffd_ram.sv]
`default_nettype none
module mffd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/mffd_fifo.sv]
`default_nettype none
module mffd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic do_wr, do_rd;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = q_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wp_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule
`default_nettype wire

[rtl/mffd_back.sv]
`default_nettype none
module mffd_back
  import mffd_pkg::*;
#(
  parameter int SEEN_DEPTH = 128,
  parameter int MAX_TEXT   = 200
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] my_node_id,
  input  wire logic        req_valid,
  input  wire req_t        req,
  output logic             req_take,
  output logic             res_wr,
  output res_t             res,
  input  wire logic        res_room,
  output logic             clr_busy
);
  localparam int SA = $clog2(SEEN_DEPTH);
  localparam int TW = $clog2(MAX_TEXT);

  back_state_t st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [31:0] hw_r [3];
  logic [31:0] hw_nxt [3];
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic [31:0] btc_r, btc_nxt;
  logic [TW-1:0] tc_r, tc_nxt;
  logic [31:0] port_r, port_nxt;
  logic        tne_r, tne_nxt;
  logic        drop_r, drop_nxt;
  logic [SA-1:0] next_r, next_nxt;

  // ring search and clear
  logic [SA:0]   scan_r, scan_nxt;
  logic          hit_r, hit_nxt;
  logic          clr_r;
  logic [SA-1:0] clr_a_r;
  logic          rvalid_r;
  logic [SA-1:0] raddr;
  logic [31:0]   rdata;
  logic          we;
  logic [SA-1:0] waddr;
  logic [31:0]   wdata;

  // pending results of the current request
  res_t text_r, text_nxt, verd_r, verd_nxt;
  logic have_text_r, have_text_nxt, have_verd_r, have_verd_nxt;

  mffd_ram #(.WIDTH(32), .DEPTH(SEEN_DEPTH)) u_seen (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign clr_busy = clr_r;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_a_r <= '0;
    end else if (clr_r) begin
      clr_a_r <= clr_a_r + 1'b1;
      if (clr_a_r == SA'(SEEN_DEPTH-1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ph_r <= PH_HEADER;
      pos_r <= '0;
      hw_r[0] <= '0; hw_r[1] <= '0; hw_r[2] <= '0;
      tag_r <= '0; acc_r <= '0; sh_r <= '0; btc_r <= '0; tc_r <= '0;
      port_r <= '0; tne_r <= 1'b0; drop_r <= 1'b0; next_r <= '0;
      scan_r <= '0; hit_r <= 1'b0; rvalid_r <= 1'b0;
      have_text_r <= 1'b0; have_verd_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; pos_r <= pos_nxt;
      hw_r <= hw_nxt;
      tag_r <= tag_nxt; acc_r <= acc_nxt; sh_r <= sh_nxt; btc_r <= btc_nxt;
      tc_r <= tc_nxt; port_r <= port_nxt; tne_r <= tne_nxt; drop_r <= drop_nxt;
      next_r <= next_nxt; scan_r <= scan_nxt; hit_r <= hit_nxt;
      rvalid_r <= (st_nxt == BK_SEARCH);
      have_text_r <= have_text_nxt; have_verd_r <= have_verd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    text_r <= text_nxt;
    verd_r <= verd_nxt;
  end

  assign raddr = scan_r[SA-1:0];

  always_comb begin
    logic [7:0]  b;
    logic        dropping;
    logic [31:0] hdr_id;
    logic [2:0]  wt;
    st_nxt = st_r; ph_nxt = ph_r; pos_nxt = pos_r; hw_nxt = hw_r;
    tag_nxt = tag_r; acc_nxt = acc_r; sh_nxt = sh_r; btc_nxt = btc_r;
    tc_nxt = tc_r; port_nxt = port_r; tne_nxt = tne_r; drop_nxt = drop_r;
    next_nxt = next_r; scan_nxt = scan_r; hit_nxt = hit_r;
    text_nxt = text_r; verd_nxt = verd_r;
    have_text_nxt = have_text_r; have_verd_nxt = have_verd_r;
    req_take = 1'b0; res_wr = 1'b0; res = text_r;
    we = clr_r; waddr = clr_a_r; wdata = '0;
    b = req.data_byte;
    hdr_id = hw_r[2];
    dropping = 1'b0;
    wt = 3'd0;

    unique case (st_r)
      BK_IDLE: begin
        if (req_valid && !clr_r) begin
          if (req.action) begin
            req_take = 1'b1;
            we = 1'b1; waddr = next_r; wdata = req.own_id;
            next_nxt = (next_r == SA'(SEEN_DEPTH-1)) ? '0 : next_r + 1'b1;
          end else if (ph_r != PH_HEADER && !drop_r && pos_r == 5'd17) begin
            // addressed check, then search the ring
            if (hw_r[0] != BROADCAST_ID && hw_r[0] != my_node_id) begin
              ph_nxt = PH_DROP_ADDR; drop_nxt = 1'b1;
              st_nxt = BK_EMIT;
            end else begin
              scan_nxt = '0; hit_nxt = 1'b0;
              st_nxt = BK_SEARCH;
            end
          end else begin
            st_nxt = BK_EMIT;
          end
        end
      end
      BK_SEARCH: begin
        if (rvalid_r && rdata == hdr_id) begin
          hit_nxt = 1'b1;
        end
        if (scan_r != (SA+1)'(SEEN_DEPTH)) begin
          scan_nxt = scan_r + 1'b1;
        end else if (!rvalid_r || hit_r || rdata == hdr_id) begin
          if (hit_r || (rvalid_r && rdata == hdr_id)) begin
            ph_nxt = PH_DROP_DUP; drop_nxt = 1'b1;
          end else begin
            we = 1'b1; waddr = next_r; wdata = hdr_id;
            next_nxt = (next_r == SA'(SEEN_DEPTH-1)) ? '0 : next_r + 1'b1;
          end
          st_nxt = BK_EMIT;
        end else begin
          we = 1'b1; waddr = next_r; wdata = hdr_id;
          next_nxt = (next_r == SA'(SEEN_DEPTH-1)) ? '0 : next_r + 1'b1;
          st_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        // first pass: process byte into pending results
        if (!have_text_r && !have_verd_r) begin
          req_take = 1'b1;
          dropping = drop_r;
          if (ph_r == PH_HEADER) begin
            if (pos_r < 5'd12) begin
              hw_nxt[pos_r[3:2]] = hw_r[pos_r[3:2]] | ({24'd0, b} << {pos_r[1:0], 3'b000});
            end
            if (pos_r >= 5'd15) ph_nxt = PH_TAG;
          end else if (!dropping) begin
            unique case (ph_r)
              PH_TAG: begin
                tag_nxt = b; acc_nxt = '0; sh_nxt = '0;
                wt = b[2:0];
                if (wt == WT_VARINT) ph_nxt = PH_VARINT;
                else if (wt == WT_LENDELIM) ph_nxt = PH_LENGTH;
                else ph_nxt = PH_STOP;
              end
              PH_VARINT, PH_LENGTH: begin
                if (sh_r < 6'd32) acc_nxt = acc_r | ({25'd0, b[6:0]} << sh_r[4:0]);
                if (b[7]) begin
                  sh_nxt = (sh_r + 6'd7 > 6'd35) ? 6'd35 : sh_r + 6'd7;
                end else if (ph_r == PH_VARINT) begin
                  if (tag_r[7:3] == FIELD_PORT) port_nxt = acc_nxt;
                  ph_nxt = PH_TAG;
                end else if (acc_nxt == '0) begin
                  ph_nxt = PH_TAG;
                end else begin
                  btc_nxt = acc_nxt;
                  if (tag_r[7:3] == FIELD_TEXT) begin
                    tne_nxt = 1'b0; tc_nxt = '0; ph_nxt = PH_TEXT;
                  end else begin
                    ph_nxt = PH_SKIP;
                  end
                end
              end
              PH_TEXT: begin
                if (32'(tc_r) < 32'(MAX_TEXT-1)) begin
                  if (tc_r == '0) tne_nxt = (b != 8'd0);
                  text_nxt = '0;
                  text_nxt.text_byte = b;
                  text_nxt.text_first = (tc_r == '0);
                  text_nxt.sender_id = hw_r[1];
                  have_text_nxt = 1'b1;
                  tc_nxt = tc_r + 1'b1;
                end
                btc_nxt = btc_r - 1'b1;
                if (btc_nxt == '0) ph_nxt = PH_TAG;
              end
              PH_SKIP: begin
                btc_nxt = btc_r - 1'b1;
                if (btc_nxt == '0) ph_nxt = PH_TAG;
              end
              default: ;
            endcase
          end
          if (pos_r < 5'd18) pos_nxt = pos_r + 1'b1;
          if (req.last_byte) begin
            verd_nxt = '0;
            verd_nxt.kind = 1'b1;
            verd_nxt.frame_done = 1'b1;
            verd_nxt.sender_id = hw_nxt[1];
            if (pos_nxt < 5'd18) begin
              verd_nxt.verdict = V_SHORT;
            end else if (ph_nxt == PH_DROP_ADDR) begin
              verd_nxt.verdict = V_NOT_ADDR;
            end else if (ph_nxt == PH_DROP_DUP) begin
              verd_nxt.verdict = V_DUP;
            end else begin
              verd_nxt.port_number = port_nxt;
              if (ph_nxt == PH_VARINT && tag_nxt[7:3] == FIELD_PORT)
                verd_nxt.port_number = acc_nxt;
              if (ph_nxt == PH_LENGTH && tag_nxt[7:3] == FIELD_TEXT && acc_nxt != '0)
                verd_nxt.verdict = V_NO_TEXT;
              else
                verd_nxt.verdict = tne_nxt ? V_ACCEPTED : V_NO_TEXT;
            end
            have_verd_nxt = 1'b1;
            // frame state back to reset
            ph_nxt = PH_HEADER; pos_nxt = '0;
            hw_nxt[0] = '0; hw_nxt[1] = '0; hw_nxt[2] = '0;
            tag_nxt = '0; acc_nxt = '0; sh_nxt = '0; btc_nxt = '0; tc_nxt = '0;
            port_nxt = '0; tne_nxt = 1'b0; drop_nxt = 1'b0;
          end
          if (!have_text_nxt && !have_verd_nxt) st_nxt = BK_IDLE;
        end else if (res_room) begin
          // drain pending results, text first
          res_wr = 1'b1;
          if (have_text_r) begin
            res = text_r; have_text_nxt = 1'b0;
            if (!have_verd_r) st_nxt = BK_IDLE;
          end else begin
            res = verd_r; have_verd_nxt = 1'b0;
            st_nxt = BK_IDLE;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/mesh_frame_filter_decoder.sv]
// Channel  | Direction | Handshake         | Ports
// input    | in        | in_push / in_full | in_action in_data_byte in_last_byte in_own_id
// result   | out       | out_empty/out_pop | out_kind out_text_byte out_text_first ...
// config   | in        | cfg_we            | cfg_my_node_id
//
// A frame byte passes through the back end as a decode step, then one drain step per
// result drained; an own-id record is taken straight from the idle state.
// The 18th byte of an addressed frame adds a search of every ring entry
// over the single-read-port seen-id memory.
// After reset a clearing pass zeroes every ring entry; requests wait.
// Input and result queues are two deep, so each side stalls on its own.
`default_nettype none
module mesh_frame_filter_decoder
  import mffd_pkg::*;
#(
  parameter int SEEN_DEPTH = 128,
  parameter int MAX_TEXT   = 200
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_my_node_id,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [31:0] in_own_id,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_kind,
  output logic [7:0]       out_text_byte,
  output logic             out_text_first,
  output logic [2:0]       out_verdict,
  output logic [31:0]      out_sender_id,
  output logic [31:0]      out_port_number,
  output logic             out_frame_done
);
  logic [31:0] node_r;
  req_t in_req, q_req;
  logic q_empty, req_take, res_wr, res_full, clr_busy;
  res_t res, out_res;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= '0;
    end else if (cfg_we) begin
      node_r <= cfg_my_node_id;
    end
  end

  assign in_req = '{action: in_action, data_byte: in_data_byte,
                    last_byte: in_last_byte, own_id: in_own_id};

  // front queue
  mffd_fifo #(.WIDTH($bits(req_t)), .DEPTH(2)) u_in_q (
    .clk(clk), .rst_n(rst_n), .wr(in_push), .wdata(in_req), .full(in_full),
    .rd(req_take), .rdata(q_req), .empty(q_empty)
  );

  mffd_back #(.SEEN_DEPTH(SEEN_DEPTH), .MAX_TEXT(MAX_TEXT)) u_back (
    .clk(clk), .rst_n(rst_n), .my_node_id(node_r),
    .req_valid(!q_empty), .req(q_req), .req_take(req_take),
    .res_wr(res_wr), .res(res), .res_room(!res_full), .clr_busy(clr_busy)
  );

  // result queue
  mffd_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_out_q (
    .clk(clk), .rst_n(rst_n), .wr(res_wr), .wdata(res), .full(res_full),
    .rd(out_pop), .rdata(out_res), .empty(out_empty)
  );

  assign out_kind        = out_res.kind;
  assign out_text_byte   = out_res.text_byte;
  assign out_text_first  = out_res.text_first;
  assign out_verdict     = out_res.verdict;
  assign out_sender_id   = out_res.sender_id;
  assign out_port_number = out_res.port_number;
  assign out_frame_done  = out_res.frame_done;

  // checks
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !req_take) else $error("request taken during ring clear");
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> !res_full) else $error("result written into full queue");
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> !q_empty) else $error("request taken from empty queue");
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb
  import mffd_pkg::*;
();

  localparam int RING = 128;
  localparam int TEXT_CAP = 199;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 1900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_my_node_id = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_action = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic in_last_byte = 1'b0;
  logic [31:0] in_own_id = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_kind;
  logic [7:0] out_text_byte;
  logic out_text_first;
  logic [2:0] out_verdict;
  logic [31:0] out_sender_id;
  logic [31:0] out_port_number;
  logic out_frame_done;

  mesh_frame_filter_decoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_my_node_id(cfg_my_node_id),
    .in_push(in_push), .in_full(in_full), .in_action(in_action),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte), .in_own_id(in_own_id),
    .out_empty(out_empty), .out_pop(out_pop), .out_kind(out_kind),
    .out_text_byte(out_text_byte), .out_text_first(out_text_first),
    .out_verdict(out_verdict), .out_sender_id(out_sender_id),
    .out_port_number(out_port_number), .out_frame_done(out_frame_done)
  );

  always #4 clk = ~clk;

  // expected results, oldest first
  res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int out_hold = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  // decoder model state
  logic [31:0] node_id;
  logic [31:0] seen_ring[RING];
  int          ring_next;
  phase_t      phase;
  int          byte_pos;
  logic [31:0] hdr[3];
  logic [7:0]  tag;
  logic [31:0] accum;
  int          shift;
  logic [31:0] remaining;
  int          text_cnt;
  logic [31:0] port_val;
  bit          text_ok;
  bit          dropped;

  // ids already sent, reused to provoke duplicates
  logic [31:0] sent_ids[$];

  function automatic void clear_frame();
    phase = PH_HEADER;
    byte_pos = 0;
    hdr[0] = '0; hdr[1] = '0; hdr[2] = '0;
    tag = '0; accum = '0; shift = 0; remaining = '0;
    text_cnt = 0; port_val = '0; text_ok = 1'b0; dropped = 1'b0;
  endfunction

  function automatic void record_id(logic [31:0] id);
    seen_ring[ring_next] = id;
    ring_next = (ring_next + 1) % RING;
  endfunction

  function automatic bit id_in_ring(logic [31:0] id);
    foreach (seen_ring[i]) if (seen_ring[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void add_result(bit k, logic [7:0] tb_, bit first, verdict_t v,
                                     logic [31:0] port, bit done);
    res_t r;
    r.kind = k; r.text_byte = tb_; r.text_first = first; r.verdict = v;
    r.sender_id = hdr[1]; r.port_number = port; r.frame_done = done;
    expected_results.push_back(r);
  endfunction

  // protobuf payload byte
  function automatic void payload_byte(logic [7:0] b);
    case (phase)
      PH_TAG: begin
        tag = b; accum = '0; shift = 0;
        if (b[2:0] == WT_VARINT) phase = PH_VARINT;
        else if (b[2:0] == WT_LENDELIM) phase = PH_LENGTH;
        else phase = PH_STOP;
      end
      PH_VARINT, PH_LENGTH: begin
        if (shift < 32) accum |= 32'(b[6:0]) << shift;
        if (b[7]) begin
          shift = (shift + 7 > 35) ? 35 : shift + 7;
        end else if (phase == PH_VARINT) begin
          if (tag[7:3] == FIELD_PORT) port_val = accum;
          phase = PH_TAG;
        end else if (accum == 0) begin
          phase = PH_TAG;
        end else begin
          remaining = accum;
          if (tag[7:3] == FIELD_TEXT) begin
            text_ok = 1'b0; text_cnt = 0; phase = PH_TEXT;
          end else begin
            phase = PH_SKIP;
          end
        end
      end
      PH_TEXT: begin
        if (text_cnt < TEXT_CAP) begin
          if (text_cnt == 0) text_ok = (b != 0);
          add_result(1'b0, b, text_cnt == 0, V_ACCEPTED, '0, 1'b0);
          text_cnt++;
        end
        remaining--;
        if (remaining == 0) phase = PH_TAG;
      end
      PH_SKIP: begin
        remaining--;
        if (remaining == 0) phase = PH_TAG;
      end
      default: ;
    endcase
  endfunction

  // one accepted request into expected results
  function automatic void decode_request(bit act, logic [7:0] b, bit last, logic [31:0] id);
    verdict_t v;
    logic [31:0] port;
    if (act) begin
      record_id(id);
      return;
    end
    if (phase == PH_HEADER) begin
      if (byte_pos < 12) hdr[byte_pos >> 2] |= 32'(b) << (8 * (byte_pos % 4));
      if (byte_pos >= 15) phase = PH_TAG;
    end else if (!dropped) begin
      if (byte_pos == 17) begin
        if (hdr[0] != BROADCAST_ID && hdr[0] != node_id) begin
          phase = PH_DROP_ADDR; dropped = 1'b1;
        end else if (id_in_ring(hdr[2])) begin
          phase = PH_DROP_DUP; dropped = 1'b1;
        end else begin
          record_id(hdr[2]);
        end
      end
      if (!dropped) payload_byte(b);
    end
    if (byte_pos < 18) byte_pos++;
    if (last) begin
      port = '0;
      if (byte_pos < 18) v = V_SHORT;
      else if (phase == PH_DROP_ADDR) v = V_NOT_ADDR;
      else if (phase == PH_DROP_DUP) v = V_DUP;
      else begin
        if (phase == PH_VARINT && tag[7:3] == FIELD_PORT) port_val = accum;
        if (phase == PH_LENGTH && tag[7:3] == FIELD_TEXT && accum != 0) text_ok = 1'b0;
        v = text_ok ? V_ACCEPTED : V_NO_TEXT;
        port = port_val;
      end
      add_result(1'b1, '0, 1'b0, v, port, 1'b1);
      clear_frame();
    end
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one request; returns at the edge that accepts it
  task automatic send_request(bit act, logic [7:0] b, bit last, logic [31:0] id);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_action <= act;
    in_data_byte <= b;
    in_last_byte <= last;
    in_own_id <= id;
    do @(posedge clk); while (in_full);
    decode_request(act, b, last, id);
    if (act) sent_ids.push_back(id);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_id(logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_my_node_id <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_id = val;
  endtask

  function automatic void put_varint(ref logic [7:0] f[$], input logic [31:0] val,
                                     input bit pad);
    int n;
    n = 0;
    do begin
      if (val > 32'h7F || (pad && n < 5)) f.push_back({1'b1, val[6:0]});
      else f.push_back({1'b0, val[6:0]});
      val = val >> 7;
      n++;
    end while (f[$][7]);
  endfunction

  // random frame with a well-formed header and a random protobuf payload, sometimes cut short
  function automatic void build_frame(ref logic [7:0] f[$]);
    logic [31:0] dest, from, id, flags, len;
    int r, nf, kind, cut;
    r = $urandom_range(0, 99);
    dest = (r < 45) ? BROADCAST_ID : (r < 85) ? node_id : $urandom();
    from = $urandom();
    r = $urandom_range(0, 99);
    if (r < 15 && sent_ids.size() > 0) id = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
    else if (r < 19) id = '0;
    else id = $urandom();
    flags = $urandom();
    sent_ids.push_back(id);
    if (sent_ids.size() > 200) void'(sent_ids.pop_front());
    for (int i = 0; i < 4; i++) f.push_back(dest[8*i +: 8]);
    for (int i = 0; i < 4; i++) f.push_back(from[8*i +: 8]);
    for (int i = 0; i < 4; i++) f.push_back(id[8*i +: 8]);
    for (int i = 0; i < 4; i++) f.push_back(flags[8*i +: 8]);
    nf = $urandom_range(1, 4);
    for (int k = 0; k < nf; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        f.push_back(8'h08);
        put_varint(f, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 300),
                   $urandom_range(0, 9) == 0);
      end else if (kind < 75) begin
        len = ($urandom_range(0, 60) == 0) ? $urandom_range(199, 215) : $urandom_range(0, 12);
        f.push_back(8'h12);
        put_varint(f, len, 1'b0);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len);
        for (int i = 0; i < len; i++)
          f.push_back((i == 0 && $urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom()));
      end else if (kind < 85) begin
        f.push_back({5'($urandom_range(3, 31)), WT_VARINT});
        put_varint(f, $urandom(), 1'b0);
      end else if (kind < 95) begin
        len = $urandom_range(0, 6);
        f.push_back({5'($urandom_range(3, 31)), WT_LENDELIM});
        put_varint(f, len, 1'b0);
        for (int i = 0; i < len; i++) f.push_back(8'($urandom()));
      end else begin
        f.push_back({5'($urandom()), 3'($urandom_range(3, 7))});
        f.push_back(8'($urandom()));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      cut = $urandom_range(1, 17);
      while (f.size() > cut) void'(f.pop_back());
    end else if (r < 15) begin
      cut = $urandom_range(18, f.size());
      while (f.size() > cut) void'(f.pop_back());
    end
  endfunction

  // directed request table
  typedef struct {
    bit          act;
    logic [7:0]  data;
    bit          last;
    logic [31:0] id;
    bit          typed;
    verdict_t    verdict;
  } row_t;
  row_t directed[$];

  function automatic void add_row(bit act, logic [7:0] d, bit last, logic [31:0] id,
                                  bit typed, verdict_t v);
    row_t r;
    r.act = act; r.data = d; r.last = last; r.id = id; r.typed = typed; r.verdict = v;
    directed.push_back(r);
  endfunction

  // result checker
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && !out_empty && out_pop) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual kind %0d verdict %0d",
                 $time, out_kind, out_verdict);
      end else begin
        e = expected_results.pop_front();
        check_field("kind", e.kind, out_kind);
        check_field("text_byte", e.text_byte, out_text_byte);
        check_field("text_first", e.text_first, out_text_first);
        check_field("verdict", e.verdict, out_verdict);
        check_field("sender_id", e.sender_id, out_sender_id);
        check_field("port_number", e.port_number, out_port_number);
        check_field("frame_done", e.frame_done, out_frame_done);
      end
    end
  end

  // result-side stalls: hold pop low for a random gap, then raise it
  always @(posedge clk) begin
    if (quiet_out) begin
      out_hold = 0;
      out_pop <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_pop <= 1'b0;
    end else begin
      out_hold = pick_gap(1'b0);
      out_pop <= (out_hold == 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL mesh_frame_filter_decoder");
      $finish;
    end
  end

  initial begin
    int sent;
    logic [7:0] frame[$];
    logic [31:0] settings[4];
    node_id = '0;
    foreach (seen_ring[i]) seen_ring[i] = '0;
    ring_next = 0;
    clear_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // short frame, id zero counted as seen, own id record with ignored fields
    add_row(1'b0, 8'h11, 1'b0, 32'hFFFF_FFFF, 1'b0, V_ACCEPTED);
    add_row(1'b0, 8'h22, 1'b0, '0, 1'b0, V_ACCEPTED);
    add_row(1'b0, 8'h33, 1'b1, '0, 1'b1, V_SHORT);
    for (int i = 0; i < 4; i++) add_row(1'b0, 8'hFF, 1'b0, '0, 1'b0, V_ACCEPTED);
    for (int i = 0; i < 4; i++) add_row(1'b0, 8'h5A, 1'b0, '0, 1'b0, V_ACCEPTED);
    for (int i = 0; i < 4; i++) add_row(1'b0, 8'h00, 1'b0, '0, 1'b0, V_ACCEPTED);
    for (int i = 0; i < 4; i++) add_row(1'b0, 8'hA5, 1'b0, '0, 1'b0, V_ACCEPTED);
    add_row(1'b0, 8'h08, 1'b0, '0, 1'b0, V_ACCEPTED);
    add_row(1'b0, 8'h01, 1'b1, '0, 1'b1, V_DUP);
    add_row(1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0, V_ACCEPTED);
    foreach (directed[i]) begin
      send_request(directed[i].act, directed[i].data, directed[i].last, directed[i].id);
      if (directed[i].typed) expected_results[$].verdict = directed[i].verdict;
    end
    wait_idle();

    // random frames under several node ids, extremes among them
    settings[0] = 32'hFFFF_FFFF;
    settings[1] = '0;
    settings[2] = $urandom();
    settings[3] = 32'h8000_0001;
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      write_node_id(settings[p]);
      while (sent < (p + 1) * ITEM_TARGET / 4) begin
        frame.delete();
        build_frame(frame);
        quiet_in = ($urandom_range(0, 4) == 0);
        quiet_out = ($urandom_range(0, 4) == 0);
        foreach (frame[i]) begin
          if ($urandom_range(0, 40) == 0)
            send_request(1'b1, 8'($urandom()), 1'($urandom()), $urandom());
          send_request(1'b0, frame[i], i == frame.size() - 1, $urandom());
          sent++;
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS mesh_frame_filter_decoder");
    end else begin
      $display("FAIL mesh_frame_filter_decoder");
    end
    $finish;
  end

endmodule
